/* hdl/nss_pkg.sv */
// shared types, constants and register map of the navigation safety supervisor
`timescale 1ns / 1ps
package nss_pkg;

   localparam int LOW_FEATURE_CAP_DEF = 10;

   // multiplier and divider sizing
   localparam int MUL_AW   = 16;
   localparam int MUL_XW   = 20;
   localparam int MUL_ACCW = 38;
   localparam int DIV_NW   = 38;
   localparam int DIV_DW   = 20;

   localparam int CSR_AW = 5;

   // register indexes
   localparam logic [2:0] REG_PAUSE_DIST = 3'd0;
   localparam logic [2:0] REG_BLOCK_DIST = 3'd1;
   localparam logic [2:0] REG_MIN_SPEED  = 3'd2;
   localparam logic [2:0] REG_MAX_SPEED  = 3'd3;
   localparam logic [2:0] REG_WINDOW     = 3'd4;
   localparam logic [2:0] REG_THRESHOLD  = 3'd5;

   // event codes
   localparam logic [1:0] ACT_KEYFRAME = 2'd0;
   localparam logic [1:0] ACT_STATUS   = 2'd1;
   localparam logic [1:0] ACT_PAUSE    = 2'd2;
   localparam logic [1:0] ACT_RESUME   = 2'd3;

   // drift action codes
   localparam logic [1:0] DRIFT_CONTINUE = 2'd0;
   localparam logic [1:0] DRIFT_PAUSE    = 2'd1;
   localparam logic [1:0] DRIFT_HALT     = 2'd2;

   typedef struct packed {
      logic [1:0]  action;
      logic        odometry_failed;
      logic        map_match_failed;
      logic [11:0] match_count;
      logic        is_following;
      logic [19:0] drift_mm;
      logic        is_obstructed;
      logic [15:0] elapsed_ms;
   } nss_req_type;

   typedef struct packed {
      logic [1:0]  drift_action;
      logic        obstruction_action;
      logic        feature_action;
      logic [15:0] speed_limit_mm_s;
      logic        operator_action;
      logic [19:0] filtered_matches_q8;
   } nss_rsp_type;

   // handshake between the sequencer and an arithmetic unit
   typedef struct packed {
      logic start;
   } nss_unit_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } nss_unit_sts_type;

endpackage

/* hdl/nss_mul.sv */
// bit-serial multiply-accumulate of two product pairs, msb first
`timescale 1ns / 1ps
module nss_mul
   import nss_pkg::*;
#(
   parameter int AW   = MUL_AW,
   parameter int XW   = MUL_XW,
   parameter int ACCW = MUL_ACCW
) (
   input  logic             clock,
   input  logic             reset,
   input  nss_unit_cmd_type cmd,
   input  logic [AW-1:0]    a,
   input  logic [XW-1:0]    x,
   input  logic [AW-1:0]    b,
   input  logic [XW-1:0]    y,
   output nss_unit_sts_type sts,
   output logic [ACCW-1:0]  acc
);

   localparam int CW = $clog2(AW + 1);

   logic [AW-1:0]   a_ff, a_in, b_ff, b_in;
   logic [XW-1:0]   x_ff, x_in, y_ff, y_in;
   logic [ACCW-1:0] acc_ff, acc_in;
   logic [CW-1:0]   cnt_ff, cnt_in;
   logic            done_ff, done_in;
   logic [ACCW-1:0] term_x, term_y;

   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      term_x  = a_ff[AW-1] ? ACCW'(x_ff) : '0;
      term_y  = b_ff[AW-1] ? ACCW'(y_ff) : '0;
      if (cmd.start) begin
         a_in   = a;
         b_in   = b;
         x_in   = x;
         y_in   = y;
         acc_in = '0;
         cnt_in = CW'(AW);
      end else if (cnt_ff != '0) begin
         acc_in = {acc_ff[ACCW-2:0], 1'b0} + term_x + term_y;
         a_in   = {a_ff[AW-2:0], 1'b0};
         b_in   = {b_ff[AW-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         done_in = (cnt_ff == CW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      a_ff   <= a_in;
      b_ff   <= b_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
      acc_ff <= acc_in;
   end

   assign sts.busy = (cnt_ff != '0);
   assign sts.done = done_ff;
   assign acc      = acc_ff;

endmodule

/* hdl/nss_div.sv */
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module nss_div
   import nss_pkg::*;
#(
   parameter int NW = DIV_NW,
   parameter int DW = DIV_DW
) (
   input  logic             clock,
   input  logic             reset,
   input  nss_unit_cmd_type cmd,
   input  logic [NW-1:0]    num,
   input  logic [DW-1:0]    den,
   output nss_unit_sts_type sts,
   output logic [NW-1:0]    quo,
   output logic [DW-1:0]    rem
);

   localparam int CW = $clog2(NW + 1);

   logic [NW-1:0] n_ff, n_in;
   logic [DW-1:0] d_ff, d_in;
   logic [DW-1:0] r_ff, r_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          done_ff, done_in;
   logic [DW:0]   trial;
   logic          fits;

   always_comb begin
      n_in    = n_ff;
      d_in    = d_ff;
      r_in    = r_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      trial   = {r_ff, n_ff[NW-1]};
      fits    = (trial >= {1'b0, d_ff});
      if (cmd.start) begin
         n_in   = num;
         d_in   = den;
         r_in   = '0;
         cnt_in = CW'(NW);
      end else if (cnt_ff != '0) begin
         r_in    = fits ? DW'(trial - {1'b0, d_ff}) : trial[DW-1:0];
         n_in    = {n_ff[NW-2:0], fits};
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == CW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      n_ff <= n_in;
      d_ff <= d_in;
      r_ff <= r_in;
   end

   assign sts.busy = (cnt_ff != '0);
   assign sts.done = done_ff;
   assign quo      = n_ff;
   assign rem      = r_ff;

endmodule

/* hdl/navigation_safety_supervisor_top.sv */
// navigation safety supervisor: register port, event handling and sequencer
`timescale 1ns / 1ps
// keyframe, pause, resume and non-following status items: result in the cycle after accept
// following status items: result follows two serial multiplies
// and two serial divides run back to back on one multiplier and one divider
// one item in flight; the next is taken once the result register is free or being taken
// synchronous active-high reset loads register defaults and clears all monitor state
// speed limit reads 0 until the first following status item
module navigation_safety_supervisor_top
   import nss_pkg::*;
#(
   parameter int LOW_FEATURE_CAP = LOW_FEATURE_CAP_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  nss_req_type       req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output nss_rsp_type       rsp_payload,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   // sequencer states
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MUL1 = 3'd1;
   localparam logic [2:0] ST_DIV1 = 3'd2;
   localparam logic [2:0] ST_MUL2 = 3'd3;
   localparam logic [2:0] ST_DIV2 = 3'd4;
   localparam logic [2:0] ST_FIN  = 3'd5;

   localparam logic [11:0] CAP = 12'(LOW_FEATURE_CAP);

   // configuration registers
   logic [19:0] pause_ff, block_ff;
   logic [15:0] min_speed_ff, max_speed_ff, window_ff;
   logic [11:0] thr_ff;
   logic [2:0]  csr_idx;
   logic        csr_wr;

   // held event state
   logic        odo_fail_ff, odo_fail_in;
   logic        match_fail_ff, match_fail_in;
   logic [11:0] held_count_ff, held_count_in;
   logic        latch_ff, latch_in;
   logic [19:0] filter_ff, filter_in;
   logic [1:0]  drift_ff, drift_in;
   logic        obstr_ff, obstr_in;
   logic        feature_ff, feature_in;
   logic [15:0] speed_ff, speed_in;
   logic        operator_ff, operator_in;

   logic [2:0]  state_ff, state_in;
   logic        rsp_valid_ff, rsp_valid_in;
   nss_rsp_type rsp_ff, rsp_in;
   logic        sign_ff, sign_in;
   logic [15:0] wdw_ff, wdw_in;
   logic [DIV_NW-1:0] q_ff, q_in;
   logic        rnz_ff, rnz_in;

   // arithmetic units
   nss_unit_cmd_type mul_cmd, div_cmd;
   nss_unit_sts_type mul_sts, div_sts;
   logic [MUL_AW-1:0]   mul_a, mul_b;
   logic [MUL_XW-1:0]   mul_x, mul_y;
   logic [MUL_ACCW-1:0] mul_acc;
   logic [DIV_NW-1:0]   div_num, div_quo;
   logic [DIV_DW-1:0]   div_den, div_rem;

   logic        accept, start_status;
   logic [15:0] w_req, t_req;
   logic [19:0] f_new;
   logic [11:0] d_slope;
   logic [19:0] den_speed;
   logic [16:0] dspeed;
   logic [20:0] dfeat;
   logic [15:0] dspeed_mag;
   logic [19:0] dfeat_mag;
   logic signed [39:0] offset, lin, lin_lo, lin_hi;

   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[4:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      case (csr_idx)
         REG_PAUSE_DIST: csr_prdata = {12'd0, pause_ff};
         REG_BLOCK_DIST: csr_prdata = {12'd0, block_ff};
         REG_MIN_SPEED:  csr_prdata = {16'd0, min_speed_ff};
         REG_MAX_SPEED:  csr_prdata = {16'd0, max_speed_ff};
         REG_WINDOW:     csr_prdata = {16'd0, window_ff};
         REG_THRESHOLD:  csr_prdata = {20'd0, thr_ff};
         default:        csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pause_ff     <= 20'd1000;
         block_ff     <= 20'd10000;
         min_speed_ff <= 16'd1000;
         max_speed_ff <= 16'd5000;
         window_ff    <= 16'd5000;
         thr_ff       <= 12'd50;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_PAUSE_DIST: pause_ff     <= csr_pwdata[19:0];
            REG_BLOCK_DIST: block_ff     <= csr_pwdata[19:0];
            REG_MIN_SPEED:  min_speed_ff <= csr_pwdata[15:0];
            REG_MAX_SPEED:  max_speed_ff <= csr_pwdata[15:0];
            REG_WINDOW:     window_ff    <= csr_pwdata[15:0];
            REG_THRESHOLD:  thr_ff       <= csr_pwdata[11:0];
            default: ;
         endcase
      end
   end

   // one item at a time; the result register frees the output side
   assign req_stall    = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign accept       = req_valid && !req_stall;
   assign start_status = accept && (req_payload.action == ACT_STATUS)
                         && req_payload.is_following;

   // window of zero behaves as one, elapsed time clamps to the window
   assign w_req = (window_ff == 16'd0) ? 16'd1 : window_ff;
   assign t_req = (req_payload.elapsed_ms < w_req) ? req_payload.elapsed_ms : w_req;

   // speed slope: denominator is (threshold - min(cap, threshold - 1)) * 256
   assign d_slope   = (thr_ff <= CAP) ? 12'd1 : (thr_ff - CAP);
   assign den_speed = {d_slope, 8'd0};

   // new filter value straight off the first divide
   assign f_new      = div_quo[19:0];
   assign dspeed     = {1'b0, max_speed_ff} - {1'b0, min_speed_ff};
   assign dfeat      = {1'b0, f_new} - {1'b0, thr_ff, 8'd0};
   assign dspeed_mag = dspeed[16] ? 16'(-dspeed) : dspeed[15:0];
   assign dfeat_mag  = dfeat[20] ? 20'(-dfeat) : dfeat[19:0];

   // floor of the signed slope term, then clamp to [min, max] with max winning
   assign offset = sign_ff ? -($signed({2'b00, q_ff}) + $signed({39'd0, rnz_ff}))
                           : $signed({2'b00, q_ff});
   assign lin    = $signed({24'd0, max_speed_ff}) + offset;
   assign lin_lo = (lin < $signed({24'd0, min_speed_ff})) ? $signed({24'd0, min_speed_ff})
                                                          : lin;
   assign lin_hi = (lin_lo > $signed({24'd0, max_speed_ff})) ? $signed({24'd0, max_speed_ff})
                                                             : lin_lo;

   always_comb begin
      odo_fail_in   = odo_fail_ff;
      match_fail_in = match_fail_ff;
      held_count_in = held_count_ff;
      latch_in      = latch_ff;
      filter_in     = filter_ff;
      drift_in      = drift_ff;
      obstr_in      = obstr_ff;
      feature_in    = feature_ff;
      speed_in      = speed_ff;
      operator_in   = operator_ff;
      state_in      = state_ff;
      sign_in       = sign_ff;
      wdw_in        = wdw_ff;
      q_in          = q_ff;
      rnz_in        = rnz_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_in        = rsp_ff;
      mul_cmd.start = 1'b0;
      div_cmd.start = 1'b0;
      mul_a         = '0;
      mul_x         = '0;
      mul_b         = '0;
      mul_y         = '0;
      div_num       = '0;
      div_den       = '0;
      // status event: drift latch and obstruction settle at once
      if (start_status) begin
         if ((req_payload.drift_mm > block_ff) && !latch_ff) begin
            latch_in = 1'b1;
            drift_in = DRIFT_HALT;
         end else if ((req_payload.drift_mm > pause_ff) || (odo_fail_ff && match_fail_ff)) begin
            drift_in = DRIFT_PAUSE;
         end else begin
            drift_in = DRIFT_CONTINUE;
         end
         if (!match_fail_ff && (req_payload.drift_mm < block_ff)) begin
            latch_in = 1'b0;
         end
         obstr_in = req_payload.is_obstructed && !latch_in;
      end
      case (state_ff)
         ST_IDLE: begin
            if (start_status) begin
               // filter numerator: (w - t) * F + t * (count << 8)
               mul_cmd.start = 1'b1;
               mul_a         = w_req - t_req;
               mul_x         = filter_ff;
               mul_b         = t_req;
               mul_y         = {held_count_ff, 8'd0};
               wdw_in        = w_req;
               state_in      = ST_MUL1;
            end else if (accept) begin
               case (req_payload.action)
                  ACT_KEYFRAME: begin
                     odo_fail_in   = req_payload.odometry_failed;
                     match_fail_in = req_payload.map_match_failed;
                     held_count_in = req_payload.match_count;
                  end
                  ACT_STATUS: begin
                     drift_in   = DRIFT_CONTINUE;
                     obstr_in   = 1'b0;
                     feature_in = 1'b0;
                  end
                  ACT_PAUSE:  operator_in = 1'b1;
                  default:    operator_in = 1'b0;
               endcase
               rsp_valid_in = 1'b1;
            end
         end
         ST_MUL1: begin
            if (mul_sts.done) begin
               // round half up
               div_cmd.start = 1'b1;
               div_num       = mul_acc + DIV_NW'(wdw_ff >> 1);
               div_den       = DIV_DW'(wdw_ff);
               state_in      = ST_DIV1;
            end
         end
         ST_DIV1: begin
            if (div_sts.done) begin
               filter_in     = f_new;
               feature_in    = !(f_new > {thr_ff, 8'd0});
               sign_in       = dspeed[16] ^ dfeat[20];
               mul_cmd.start = 1'b1;
               mul_a         = dspeed_mag;
               mul_x         = dfeat_mag;
               state_in      = ST_MUL2;
            end
         end
         ST_MUL2: begin
            if (mul_sts.done) begin
               div_cmd.start = 1'b1;
               div_num       = mul_acc;
               div_den       = den_speed;
               state_in      = ST_DIV2;
            end
         end
         ST_DIV2: begin
            if (div_sts.done) begin
               q_in     = div_quo;
               rnz_in   = (div_rem != '0);
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            speed_in     = lin_hi[15:0];
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
      if (rsp_valid_in && !(rsp_valid_ff && rsp_stall)) begin
         rsp_in.drift_action        = drift_in;
         rsp_in.obstruction_action  = obstr_in;
         rsp_in.feature_action      = feature_in;
         rsp_in.speed_limit_mm_s    = speed_in;
         rsp_in.operator_action     = operator_in;
         rsp_in.filtered_matches_q8 = filter_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         odo_fail_ff   <= 1'b0;
         match_fail_ff <= 1'b0;
         held_count_ff <= '0;
         latch_ff      <= 1'b0;
         filter_ff     <= '0;
         drift_ff      <= DRIFT_CONTINUE;
         obstr_ff      <= 1'b0;
         feature_ff    <= 1'b0;
         speed_ff      <= '0;
         operator_ff   <= 1'b0;
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
      end else begin
         odo_fail_ff   <= odo_fail_in;
         match_fail_ff <= match_fail_in;
         held_count_ff <= held_count_in;
         latch_ff      <= latch_in;
         filter_ff     <= filter_in;
         drift_ff      <= drift_in;
         obstr_ff      <= obstr_in;
         feature_ff    <= feature_in;
         speed_ff      <= speed_in;
         operator_ff   <= operator_in;
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      rsp_ff  <= rsp_in;
      sign_ff <= sign_in;
      wdw_ff  <= wdw_in;
      q_ff    <= q_in;
      rnz_ff  <= rnz_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   nss_mul #(
      .AW   (MUL_AW),
      .XW   (MUL_XW),
      .ACCW (MUL_ACCW)
   ) u_mul (
      .clock (clock),
      .reset (reset),
      .cmd   (mul_cmd),
      .a     (mul_a),
      .x     (mul_x),
      .b     (mul_b),
      .y     (mul_y),
      .sts   (mul_sts),
      .acc   (mul_acc)
   );

   nss_div #(
      .NW (DIV_NW),
      .DW (DIV_DW)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .num   (div_num),
      .den   (div_den),
      .sts   (div_sts),
      .quo   (div_quo),
      .rem   (div_rem)
   );

   // busy sequencer never takes an item
   a_busy_stalls: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> req_stall)
      else $error("item taken while sequencer busy");

   // the latch only ever sets alongside a halt action
   a_latch_halt: assert property (@(posedge clock) disable iff (reset)
      $rose(latch_ff) |-> (drift_ff == DRIFT_HALT))
      else $error("block latch set without halt");

   // speed is only finished after the second divide
   a_fin_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FIN) |-> ($past(state_ff) == ST_DIV2))
      else $error("speed stage entered out of order");

   // units never overlap: divider idle while multiplier runs
   a_unit_excl: assert property (@(posedge clock) disable iff (reset)
      mul_sts.busy |-> !div_sts.busy)
      else $error("multiplier and divider busy together");

endmodule
